FILE: rtl/nrt_pkg.sv
// ----------------------------------------------------------------------------
// nrt_pkg
// Shared types, widths and helpers for the Newton square-root-of-two block.
// ----------------------------------------------------------------------------
package nrt_pkg;

  // Field and datapath widths
  localparam int DATA_W  = 32;  // signed fixed-point estimate
  localparam int TOL_W   = 31;  // tolerance register
  localparam int STEP_W  = 7;   // step counter
  localparam int QUO_W   = 33;  // quotient bits kept before saturation
  localparam int WIDE_W  = 66;  // headroom for exact intermediate sums
  localparam int OUT_W   = 40;  // result item, padded to whole bytes
  localparam int PADDR_W = 3;   // one register, word aligned

  // Register map (register index, taken from paddr bit 2)
  localparam logic REG_TOLERANCE = 1'b0;

  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(17);

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_CALC,
    ST_DIV,
    ST_QSAT,
    ST_XNEW,
    ST_ERR,
    ST_CHECK,
    ST_DONE
  } nrt_state_e;

  // Clamp a wide signed value to the 32-bit signed range
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = $signed({{(WIDE_W-DATA_W){1'b0}}, 1'b0, {(DATA_W-1){1'b1}}});
    lo = $signed({{(WIDE_W-DATA_W){1'b1}}, 1'b1, {(DATA_W-1){1'b0}}});
    if (v > hi) begin
      sat32 = hi[DATA_W-1:0];
    end else if (v < lo) begin
      sat32 = lo[DATA_W-1:0];
    end else begin
      sat32 = v[DATA_W-1:0];
    end
  endfunction

endpackage

FILE: rtl/nrt_cfg.sv
// ----------------------------------------------------------------------------
// nrt_cfg
// APB register file holding the tolerance register; writes take effect at
// the access phase, reads return the stored value.
// ----------------------------------------------------------------------------
module nrt_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [nrt_pkg::PADDR_W-1:0]    paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output logic [nrt_pkg::TOL_W-1:0]      tolerance_o
);
  import nrt_pkg::*;

  logic [TOL_W-1:0] tol_q;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_TOLERANCE);

  // Hold the tolerance, reset to its default
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TOL_RESET;
    end else if (wr_en) begin
      tol_q <= pwdata[TOL_W-1:0];
    end
  end

  // Read back
  always_comb begin
    if (paddr[2] == REG_TOLERANCE) begin
      prdata = {{(32-TOL_W){1'b0}}, tol_q};
    end else begin
      prdata = '0;
    end
  end

  assign tolerance_o = tol_q;

endmodule

FILE: rtl/nrt_div.sv
// ----------------------------------------------------------------------------
// nrt_div
// Restoring unsigned divider, one quotient bit per cycle. Only the low
// QUO_W quotient bits are produced; a larger quotient is flagged as overflow
// and done is raised in the cycle after the start.
// ----------------------------------------------------------------------------
module nrt_div #(
  parameter int NUM_W = 56
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [NUM_W-1:0]             num_i,
  input  logic [nrt_pkg::DATA_W-1:0]   den_i,
  output logic                         done_o,
  output logic                         ovf_o,
  output logic [nrt_pkg::QUO_W-1:0]    quo_o
);
  import nrt_pkg::*;

  localparam int CNT_W = $clog2(QUO_W);

  logic [DATA_W-1:0] den_q;
  logic [DATA_W-1:0] rem_q, rem_d;
  logic [QUO_W-1:0]  sh_q, sh_d;
  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q, done_q, ovf_q;
  logic [DATA_W-1:0] num_hi;
  logic [DATA_W:0]   trial;
  logic [DATA_W+1:0] diff;

  // Upper numerator bits must stay below the divisor for the quotient to fit
  assign num_hi = DATA_W'(num_i >> QUO_W);

  // One restoring step
  always_comb begin
    trial = {rem_q, sh_q[QUO_W-1]};
    diff  = {1'b0, trial} - {2'b00, den_q};
    if (diff[DATA_W+1]) begin
      rem_d = trial[DATA_W-1:0];
    end else begin
      rem_d = diff[DATA_W-1:0];
    end
    sh_d = {sh_q[QUO_W-2:0], ~diff[DATA_W+1]};
  end

  // Control: run QUO_W steps after a start, or none when the quotient overflows
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= '0;
        if (num_hi >= den_i) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
        end
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(QUO_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: remainder, numerator/quotient shift register
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_i;
      rem_q <= num_hi;
      sh_q  <= num_i[QUO_W-1:0];
      ovf_q <= (num_hi >= den_i);
    end else if (busy_q) begin
      rem_q <= rem_d;
      sh_q  <= sh_d;
    end
  end

  assign done_o = done_q;
  assign ovf_o  = ovf_q;
  assign quo_o  = sh_q;

endmodule

FILE: rtl/newton_root_of_two.sv
// ----------------------------------------------------------------------------
// newton_root_of_two
// Newton-Raphson iteration for the square root of two in signed fixed point.
// Each Newton step runs multiply, set-up, a 33-step bit-serial divide,
// quotient, update, error and check; an overflowing quotient skips the
// bit-serial steps, and a zero-derivative step runs only multiply, set-up
// and check. One item at a time: the next is accepted in the cycle after
// the result is loaded.
// Reset: asynchronous, active low; sequencer idle, no result held, tolerance 17.
// ----------------------------------------------------------------------------
module newton_root_of_two #(
  parameter int MAX_STEPS = 100,
  parameter int FRAC_BITS = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input item
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [31:0]                   s_axis_tdata,  // [31:0] start_value
  // Result item
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [nrt_pkg::OUT_W-1:0]     m_axis_tdata,  // [31:0] root_estimate,
                                                       // [32] converged,
                                                       // [39:33] steps_used
  // Configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [nrt_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import nrt_pkg::*;

  localparam int NUM_W = DATA_W + FRAC_BITS;
  localparam logic signed [WIDE_W-1:0] TWO_W = WIDE_W'(2) <<< FRAC_BITS;

  nrt_state_e state_q, state_d;

  logic [TOL_W-1:0]         tol;
  logic signed [DATA_W-1:0] x_q, q_q, xn_q;
  logic [DATA_W-1:0]        err_q;
  logic [STEP_W-1:0]        cnt_q;
  logic [2*DATA_W-1:0]      sq_q;
  logic                     neg_q;

  logic                     in_acc, div_start, out_load, x_zero;
  logic [DATA_W-1:0]        mag;
  logic signed [WIDE_W-1:0] f_w, d_w, qm_w, q_w;
  logic signed [DATA_W-1:0] f, d, xn;
  logic [DATA_W-1:0]        fmag, dmag, err;
  logic [NUM_W-1:0]         num;
  logic signed [DATA_W:0]   diff;
  logic                     div_done, div_ovf;
  logic [QUO_W-1:0]         div_quo;
  logic                     m_valid_q;
  logic [OUT_W-1:0]         m_data_q;
  logic                     more;

  nrt_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .tolerance_o (tol)
  );

  nrt_div #(.NUM_W(NUM_W)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num),
    .den_i   (dmag),
    .done_o  (div_done),
    .ovf_o   (div_ovf),
    .quo_o   (div_quo)
  );

  // Arithmetic of one step
  always_comb begin
    mag    = x_q[DATA_W-1] ? DATA_W'(-x_q) : DATA_W'(x_q);
    x_zero = (x_q == '0);
    f_w    = $signed({2'b00, sq_q >> FRAC_BITS}) - TWO_W;
    f      = sat32(f_w);
    d_w    = WIDE_W'(x_q) <<< 1;
    d      = sat32(d_w);
    fmag   = f[DATA_W-1] ? DATA_W'(-f) : DATA_W'(f);
    dmag   = d[DATA_W-1] ? DATA_W'(-d) : DATA_W'(d);
    num    = NUM_W'(fmag) << FRAC_BITS;
    qm_w   = div_ovf ? (WIDE_W'(1) <<< QUO_W) : $signed(WIDE_W'(div_quo));
    q_w    = neg_q ? -qm_w : qm_w;
    xn     = sat32(WIDE_W'(x_q) - WIDE_W'(q_q));
    diff   = {xn_q[DATA_W-1], xn_q} - {x_q[DATA_W-1], x_q};
    err    = diff[DATA_W] ? DATA_W'(-diff) : diff[DATA_W-1:0];
    more   = (cnt_q < STEP_W'(MAX_STEPS)) && (err_q > {1'b0, tol});
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (s_axis_tvalid) state_d = ST_MUL;
      ST_MUL:   state_d = ST_CALC;
      ST_CALC:  state_d = x_zero ? ST_CHECK : ST_DIV;
      ST_DIV:   if (div_done) state_d = ST_QSAT;
      ST_QSAT:  state_d = ST_XNEW;
      ST_XNEW:  state_d = ST_ERR;
      ST_ERR:   state_d = ST_CHECK;
      ST_CHECK: state_d = more ? ST_MUL : ST_DONE;
      ST_DONE:  if (!m_valid_q || m_axis_tready) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    s_axis_tready = 1'b0;
    div_start     = 1'b0;
    out_load      = 1'b0;
    case (state_q)
      ST_IDLE: s_axis_tready = 1'b1;
      ST_CALC: div_start     = !x_zero;
      ST_DONE: out_load      = !m_valid_q || m_axis_tready;
      default: ;
    endcase
  end

  assign in_acc = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Step count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (in_acc) begin
      cnt_q <= '0;
    end else if (state_q == ST_ERR || (state_q == ST_CALC && x_zero)) begin
      cnt_q <= cnt_q + STEP_W'(1);
    end
  end

  // Estimate, error and intermediates
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x_q   <= $signed(s_axis_tdata);
      err_q <= {1'b0, tol} + DATA_W'(1);
    end
    if (state_q == ST_MUL) begin
      sq_q <= mag * mag;
    end
    if (div_start) begin
      neg_q <= f[DATA_W-1] ^ d[DATA_W-1];
    end
    if (state_q == ST_QSAT) begin
      q_q <= sat32(q_w);
    end
    if (state_q == ST_XNEW) begin
      xn_q <= xn;
    end
    if (state_q == ST_ERR) begin
      x_q   <= xn_q;
      err_q <= err;
    end
  end

  // Result register: hold until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_data_q <= {cnt_q, (err_q <= {1'b0, tol}), x_q};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

FILE: verif/nrt_checker.sv
// ----------------------------------------------------------------------------
// nrt_checker
// Watches the start, result and register channels of the Newton root block,
// predicts each result from the start value and the tolerance in force, and
// compares every accepted result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module nrt_checker #(
  parameter int MAX_STEPS = 100,
  parameter int FRAC_BITS = 24
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Start item channel
  input  logic                        start_tvalid_i,
  input  logic                        start_tready_i,
  input  logic [31:0]                 start_tdata_i,   // [31:0] start_value
  // Result item channel
  input  logic                        root_tvalid_i,
  input  logic                        root_tready_i,
  input  logic [nrt_pkg::OUT_W-1:0]   root_tdata_i,    // [31:0] root_estimate,
                                                       // [32] converged,
                                                       // [39:33] steps_used
  // Register port
  input  logic                        psel_i,
  input  logic                        penable_i,
  input  logic                        pwrite_i,
  input  logic [nrt_pkg::PADDR_W-1:0] paddr_i,
  input  logic [31:0]                 pwdata_i,
  input  logic [31:0]                 prdata_i,
  input  logic                        pready_i,
  // Status towards the testbench top
  output int                          fail_count_o,
  output int                          pending_o,
  output int                          checked_o
);
  import nrt_pkg::*;

  localparam longint Q_MAX = 64'sd2147483647;
  localparam longint Q_MIN = -64'sd2147483648;

  typedef struct packed {
    logic [STEP_W-1:0]        steps;
    logic                     converged;
    logic signed [DATA_W-1:0] root;
  } root_result_t;

  root_result_t     expected_roots[$];
  logic [TOL_W-1:0] tolerance_q;
  int               fail_cnt;

  assign fail_count_o = fail_cnt;

  // Clamp to the signed Q8.24 range
  function automatic longint clamp_q(input longint v);
    if (v > Q_MAX) return Q_MAX;
    if (v < Q_MIN) return Q_MIN;
    return v;
  endfunction

  // Run the Newton loop for one start value under the given tolerance
  function automatic root_result_t newton_predict(input logic signed [31:0] start,
                                                  input logic [TOL_W-1:0] tol);
    longint       x;
    longint       mag;
    longint       sq;
    longint       f;
    longint       d;
    longint       q;
    longint       xn;
    longint       diff;
    longint       err;
    int unsigned  steps;
    root_result_t res;
    x     = start;
    err   = longint'(tol) + 1;
    steps = 0;
    while (steps < MAX_STEPS && err > longint'(tol)) begin
      mag = (x < 0) ? -x : x;
      sq  = (mag * mag) >>> FRAC_BITS;
      f   = clamp_q(sq - (longint'(2) <<< FRAC_BITS));
      d   = clamp_q(2 * x);
      // A zero derivative leaves the estimate and the error untouched
      if (d != 0) begin
        q    = clamp_q((f <<< FRAC_BITS) / d);
        xn   = clamp_q(x - q);
        diff = xn - x;
        // Both ends are clamped, so the step always fits in 32 unsigned bits
        err  = (diff < 0) ? -diff : diff;
        x    = xn;
      end
      steps++;
    end
    res.root      = x[31:0];
    res.converged = (err <= longint'(tol));
    res.steps     = steps[STEP_W-1:0];
    return res;
  endfunction

  // Print one line per mismatch and count it
  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t  error in %s: got %0h, want %0h", $realtime, what, got, want);
    fail_cnt++;
  endtask

  initial fail_cnt = 0;

  // Track the tolerance, predict on each start item, check each result item
  always @(posedge clk_i or negedge rst_ni) begin
    root_result_t want;
    root_result_t got;
    if (!rst_ni) begin
      expected_roots.delete();
      tolerance_q <= TOL_RESET;
      pending_o   <= 0;
      checked_o   <= 0;
    end else begin
      if (psel_i && penable_i && pready_i) begin
        if (pwrite_i) begin
          if (paddr_i[2] == REG_TOLERANCE) begin
            tolerance_q <= pwdata_i[TOL_W-1:0];
          end
        end else if (prdata_i !== {1'b0, tolerance_q}) begin
          report_mismatch("tolerance read-back", prdata_i, {1'b0, tolerance_q});
        end
      end
      if (start_tvalid_i && start_tready_i) begin
        expected_roots.push_back(newton_predict(start_tdata_i, tolerance_q));
      end
      if (root_tvalid_i && root_tready_i) begin
        got = root_tdata_i[DATA_W+STEP_W:0];
        if (expected_roots.size() == 0) begin
          report_mismatch("result with nothing outstanding", root_tdata_i, 0);
        end else begin
          want = expected_roots.pop_front();
          if (got.root !== want.root) begin
            report_mismatch("root_estimate", got.root, want.root);
          end
          if (got.converged !== want.converged) begin
            report_mismatch("converged", got.converged, want.converged);
          end
          if (got.steps !== want.steps) begin
            report_mismatch("steps_used", got.steps, want.steps);
          end
        end
        checked_o <= checked_o + 1;
      end
      pending_o <= expected_roots.size();
    end
  end

endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives start values and tolerance writes into the Newton root block with
// random gaps and result back-pressure; the checker beside the block predicts
// and compares every result, and this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import nrt_pkg::*;

  localparam int          MAX_STEPS   = 100;
  localparam int          FRAC_BITS   = 24;
  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int          PHASE_ITEMS = 29;
  localparam int          TAIL_CYCLES = 60;

  localparam logic [PADDR_W-1:0] TOL_ADDR = {REG_TOLERANCE, 2'b00};
  localparam logic [31:0]        ROOT2    = 32'h016A_09E6;  // sqrt(2) in Q8.24
  localparam logic [31:0]        ONE_Q    = 32'h0100_0000;

  logic               clk   = 1'b0;
  logic               rst_n = 1'b0;

  logic               start_tvalid = 1'b0;
  logic               start_tready;
  logic [31:0]        start_tdata  = '0;
  logic               root_tvalid;
  logic               root_tready  = 1'b0;
  logic [OUT_W-1:0]   root_tdata;

  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [PADDR_W-1:0] paddr   = '0;
  logic [31:0]        pwdata  = '0;
  logic [31:0]        prdata;
  logic               pready;

  int                 fail_count;
  int                 pending;
  int                 checked;
  int unsigned        cycle_cnt = 0;
  bit                 no_idle   = 1'b0;
  int                 stall_left;
  int                 items_sent = 0;
  int                 tol_settings = 1;

  newton_root_of_two #(
    .MAX_STEPS (MAX_STEPS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (start_tvalid),
    .s_axis_tready (start_tready),
    .s_axis_tdata  (start_tdata),
    .m_axis_tvalid (root_tvalid),
    .m_axis_tready (root_tready),
    .m_axis_tdata  (root_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  nrt_checker #(
    .MAX_STEPS (MAX_STEPS),
    .FRAC_BITS (FRAC_BITS)
  ) u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start_tvalid_i (start_tvalid),
    .start_tready_i (start_tready),
    .start_tdata_i  (start_tdata),
    .root_tvalid_i  (root_tvalid),
    .root_tready_i  (root_tready),
    .root_tdata_i   (root_tdata),
    .psel_i         (psel),
    .penable_i      (penable),
    .pwrite_i       (pwrite),
    .paddr_i        (paddr),
    .pwdata_i       (pwdata),
    .prdata_i       (prdata),
    .pready_i       (pready),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .checked_o      (checked)
  );

  // Free-running clock
  initial begin
    forever #1 clk = ~clk;
  end

  // Hold reset for the first cycles, then release it for good
  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Count cycles for the watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  // Stop a run that hangs
  initial begin
    wait (cycle_cnt == CYCLE_LIMIT);
    $display("newton_root_of_two: mismatch");
    $finish;
  end

  // Stall the result side at random: mostly short stalls, a few long ones
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      root_tready <= 1'b0;
      stall_left  <= 0;
    end else if (no_idle) begin
      root_tready <= 1'b1;
      stall_left  <= 0;
    end else if (stall_left != 0) begin
      root_tready <= 1'b0;
      stall_left  <= stall_left - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      root_tready <= 1'b0;
      stall_left  <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120)
                                                 : $urandom_range(0, 3);
    end else begin
      root_tready <= 1'b1;
    end
  end

  // Pick an idle gap before the next start item
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 9);
    if (no_idle || r < 6) return 0;
    if (r < 9) return $urandom_range(1, 4);
    return $urandom_range(20, 100);
  endfunction

  // Pick a random start value: mostly plausible guesses, some raw noise
  function automatic logic [31:0] pick_start();
    logic [31:0] mag;
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: begin
        mag = $urandom_range(32'h0040_0000, 32'h0800_0000);
        v   = $urandom_range(0, 1) ? -mag : mag;
      end
      5, 6, 7: v = $urandom;
      8: begin
        mag = $urandom_range(0, 255);
        v   = $urandom_range(0, 1) ? -mag : mag;
      end
      default: begin
        case ($urandom_range(0, 4))
          0:       v = 32'h0000_0000;
          1:       v = 32'h0000_0001;
          2:       v = 32'h7FFF_FFFF;
          3:       v = 32'h8000_0000;
          default: v = 32'hFFFF_FFFF;
        endcase
      end
    endcase
    return v;
  endfunction

  // Offer one start item and hold it until accepted
  task automatic push_start(input logic [31:0] v);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start_tvalid <= 1'b1;
    start_tdata  <= v;
    @(posedge clk);
    while (!start_tready) @(posedge clk);
    items_sent++;
  endtask

  // Drop valid and wait until every outstanding result has come back
  task automatic drain();
    start_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // One register access: setup cycle, access cycle, then an idle cycle
  task automatic apb_access(input logic wr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= TOL_ADDR;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Write the tolerance and read it straight back
  task automatic set_tolerance(input logic [31:0] data);
    apb_access(1'b1, data);
    apb_access(1'b0, '0);
    tol_settings++;
  endtask

  initial begin : stimulus
    logic [31:0] tol;
    int          n_items;
    wait (rst_n);
    @(posedge clk);
    // Reset value of the tolerance
    apb_access(1'b0, '0);

    // Field extremes and special starts at the reset tolerance
    push_start(32'h0000_0000);   // zero derivative, never converges
    push_start(32'h0000_0001);
    push_start(32'hFFFF_FFFF);
    push_start(32'h0000_0002);
    push_start(32'h7FFF_FFFF);
    push_start(32'h8000_0000);   // saturates the square and the derivative
    push_start(ONE_Q);
    push_start(-ONE_Q);
    push_start(ROOT2);
    push_start(-ROOT2);
    push_start(32'h0200_0000);
    push_start(32'h4000_0000);
    push_start(32'hC000_0000);
    push_start(32'h0001_0000);
    drain();

    // Zero tolerance: exact convergence or the step limit
    set_tolerance(32'h0000_0000);
    push_start(ROOT2);
    push_start(ONE_Q);
    push_start(32'h7FFF_FFFF);
    drain();

    // Widest tolerance: one step is enough unless the derivative is zero
    set_tolerance(32'h7FFF_FFFF);
    push_start(32'h0000_0000);
    push_start(ONE_Q);
    push_start(32'h8000_0000);
    drain();

    // Random phases, each under its own tolerance
    for (int ph = 0; ph < 6; ph++) begin
      n_items = PHASE_ITEMS;
      case (ph)
        0: tol = $urandom_range(0, 255);
        1: begin
          tol     = 32'h0000_0000;
          n_items = 6;
        end
        2: tol = $urandom;
        3: tol = 32'h7FFF_FFFF;
        4: tol = $urandom_range(0, 32'h0010_0000);
        default: tol = {1'b0, TOL_RESET};
      endcase
      set_tolerance(tol);
      no_idle = (ph == 3);
      for (int i = 0; i < n_items; i++) begin
        push_start(pick_start());
      end
      drain();
    end
    no_idle = 1'b0;

    // Let the block settle after the last result
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d start values over %0d tolerance settings, %0d results checked.",
             items_sent, tol_settings, checked);
    if (fail_count == 0) begin
      $display("newton_root_of_two: match");
    end else begin
      $display("newton_root_of_two: mismatch");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/nrt_pkg.sv
rtl/nrt_cfg.sv
rtl/nrt_div.sv
rtl/newton_root_of_two.sv
verif/nrt_checker.sv
verif/tb_top.sv
